[rtl/sitrd_pkg.sv]
`timescale 1ns / 1ps

package sitrd_pkg;

	localparam int ALPHA_W    = 128;
	localparam int MAX_RADIX  = 16;
	localparam int MAX_DIGITS = 32;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;

	localparam logic [1:0] REG_RADIX    = 2'd0;
	localparam logic [1:0] REG_ALPHA_LO = 2'd1;
	localparam logic [1:0] REG_ALPHA_HI = 2'd2;

	typedef logic [3:0] pc_t;

	localparam pc_t STEP_CHECK = 4'd0;
	localparam pc_t STEP_ZTEST = 4'd1;
	localparam pc_t STEP_DIV   = 4'd2;
	localparam pc_t STEP_SIGN  = 4'd3;
	localparam pc_t STEP_READ  = 4'd4;
	localparam pc_t STEP_EMIT  = 4'd5;
	localparam pc_t STEP_IDLE  = 4'd6;
	localparam pc_t STEP_ZERO  = 4'd7;
	localparam pc_t STEP_INV   = 4'd8;

	typedef logic [3:0] op_t;

	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_LOAD = 4'd1;
	localparam op_t OP_INIT = 4'd2;
	localparam op_t OP_DIV  = 4'd3;
	localparam op_t OP_SIGN = 4'd4;
	localparam op_t OP_READ = 4'd5;
	localparam op_t OP_EMIT = 4'd6;
	localparam op_t OP_ZERO = 4'd7;
	localparam op_t OP_INV  = 4'd8;

	typedef logic [2:0] cond_t;

	localparam cond_t C_NEVER    = 3'd0;
	localparam cond_t C_ALWAYS   = 3'd1;
	localparam cond_t C_NOT_OK   = 3'd2;
	localparam cond_t C_MAG_ZERO = 3'd3;
	localparam cond_t C_DIV_MORE = 3'd4;
	localparam cond_t C_PTR_NZ   = 3'd5;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} seq_ctl_t;

	typedef struct packed {
		logic ok;
		logic mag_zero;
		logic div_more;
		logic ptr_nz;
		logic wait_step;
	} dp_stat_t;

	// microprogram: one control word per step
	function automatic ctrl_word_t ucode(input pc_t pc);
		ctrl_word_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE};
		unique case (pc)
			STEP_IDLE:  w = '{op: OP_LOAD, cond: C_ALWAYS,   target: STEP_CHECK};
			STEP_CHECK: w = '{op: OP_NONE, cond: C_NOT_OK,   target: STEP_INV};
			STEP_ZTEST: w = '{op: OP_INIT, cond: C_MAG_ZERO, target: STEP_ZERO};
			STEP_DIV:   w = '{op: OP_DIV,  cond: C_DIV_MORE, target: STEP_DIV};
			STEP_SIGN:  w = '{op: OP_SIGN, cond: C_NEVER,    target: STEP_IDLE};
			STEP_READ:  w = '{op: OP_READ, cond: C_NEVER,    target: STEP_IDLE};
			STEP_EMIT:  w = '{op: OP_EMIT, cond: C_PTR_NZ,   target: STEP_READ};
			STEP_ZERO:  w = '{op: OP_ZERO, cond: C_ALWAYS,   target: STEP_SIGN};
			STEP_INV:   w = '{op: OP_INV,  cond: C_ALWAYS,   target: STEP_IDLE};
			default:    w = '{op: OP_NONE, cond: C_ALWAYS,   target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/sitrd_cfg.sv]
`timescale 1ns / 1ps

module sitrd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [63:0]                    cfg_data,
	output logic [4:0]                     radix,
	output logic [sitrd_pkg::ALPHA_W-1:0]  alphabet,
	output logic                           alpha_ok
);

	logic [4:0]  radix_q;
	logic [63:0] alpha_lo_q;
	logic [63:0] alpha_hi_q;
	logic        ok_q;
	logic        ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= 5'd10;
			alpha_lo_q <= 64'h3736353433323130;
			alpha_hi_q <= 64'h0000000000003938;
			ok_q       <= 1'b1;
		end else begin
			ok_q <= ok_d;
			if (cfg_we) begin
				case (cfg_index)
					sitrd_pkg::REG_RADIX:    radix_q    <= cfg_data[4:0];
					sitrd_pkg::REG_ALPHA_LO: alpha_lo_q <= cfg_data;
					sitrd_pkg::REG_ALPHA_HI: alpha_hi_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign alphabet = {alpha_hi_q, alpha_lo_q};

	// radix out of range, whitespace, signs, NUL and duplicates within the used characters
	always_comb begin
		logic [7:0] ci;
		logic       bad;
		bad = (radix_q < 5'd2) || (radix_q > 5'(sitrd_pkg::MAX_RADIX));
		for (int i = 0; i < 16; i++) begin
			ci = alphabet[i*8 +: 8];
			if (5'(i) < radix_q) begin
				if (ci == 8'd0 || ci == sitrd_pkg::CH_PLUS || ci == sitrd_pkg::CH_MINUS
					|| ci == sitrd_pkg::CH_SPACE
					|| (ci >= sitrd_pkg::CH_TAB && ci <= sitrd_pkg::CH_CR))
					bad = 1'b1;
				for (int j = i + 1; j < 16; j++) begin
					if (5'(j) < radix_q && alphabet[j*8 +: 8] == ci)
						bad = 1'b1;
				end
			end
		end
		ok_d = !bad;
	end

	assign radix    = radix_q;
	assign alpha_ok = ok_q;

endmodule

[rtl/sitrd_datapath.sv]
`timescale 1ns / 1ps

module sitrd_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sitrd_pkg::seq_ctl_t            ctl,
	output sitrd_pkg::dp_stat_t            stat,
	input  logic                           in_valid,
	input  logic signed [31:0]             value,
	input  logic [4:0]                     radix,
	input  logic [sitrd_pkg::ALPHA_W-1:0]  alphabet,
	input  logic                           alpha_ok,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_char,
	output logic                           last,
	output logic                           alphabet_invalid
);

	logic [31:0] mag_q;
	logic        neg_q;
	logic [3:0]  rem_q;
	logic [1:0]  slice_q;
	logic [5:0]  count_q;
	logic [4:0]  ptr_q;
	logic [3:0]  rd_q;
	logic [3:0]  digit_mem [0:sitrd_pkg::MAX_DIGITS-1];

	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        last_q;
	logic        inval_q;

	logic [31:0] q_next;
	logic [3:0]  r_next;
	logic        emit_want;
	logic        out_free;
	logic        load_out;
	logic        slice_end;

	// eight long-division bits a cycle, remainder stays below the radix
	always_comb begin
		logic [4:0] r5;
		logic [3:0] r;
		logic [7:0] qb;
		r5 = '0;
		qb = '0;
		r  = rem_q;
		for (int k = 0; k < 8; k++) begin
			r5 = {r, mag_q[31-k]};
			if (r5 >= radix) begin
				qb[7-k] = 1'b1;
				r5      = r5 - radix;
			end
			r = r5[3:0];
		end
		q_next = {mag_q[23:0], qb};
		r_next = r;
	end

	assign slice_end = (slice_q == 2'd3);
	assign emit_want = (ctl.op == sitrd_pkg::OP_SIGN && neg_q)
		|| ctl.op == sitrd_pkg::OP_EMIT || ctl.op == sitrd_pkg::OP_INV;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = ctl.go && emit_want;

	assign stat.ok        = alpha_ok;
	assign stat.mag_zero  = (mag_q == 32'd0);
	assign stat.div_more  = !(slice_end && q_next == 32'd0);
	assign stat.ptr_nz    = (ptr_q != 5'd0);
	assign stat.wait_step = (ctl.op == sitrd_pkg::OP_LOAD && !in_valid)
		|| (emit_want && !out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q       <= '0;
			neg_q       <= 1'b0;
			slice_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (ctl.go) begin
				unique case (ctl.op)
					sitrd_pkg::OP_LOAD: begin
						neg_q <= value[31];
						mag_q <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
					end
					sitrd_pkg::OP_INIT: begin
						slice_q <= '0;
						count_q <= '0;
					end
					sitrd_pkg::OP_DIV: begin
						mag_q   <= q_next;
						slice_q <= slice_q + 2'd1;
						if (slice_end)
							count_q <= count_q + 6'd1;
					end
					sitrd_pkg::OP_ZERO: count_q <= 6'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			unique case (ctl.op)
				sitrd_pkg::OP_INIT: rem_q <= '0;
				sitrd_pkg::OP_DIV:  rem_q <= slice_end ? 4'd0 : r_next;
				sitrd_pkg::OP_SIGN: ptr_q <= 5'(count_q - 6'd1);
				sitrd_pkg::OP_EMIT: ptr_q <= ptr_q - 5'd1;
				default: ;
			endcase
		end
		if (load_out) begin
			unique case (ctl.op)
				sitrd_pkg::OP_SIGN: begin
					out_char_q <= sitrd_pkg::CH_MINUS;
					last_q     <= 1'b0;
					inval_q    <= 1'b0;
				end
				sitrd_pkg::OP_EMIT: begin
					out_char_q <= alphabet[{rd_q, 3'b000} +: 8];
					last_q     <= (ptr_q == 5'd0);
					inval_q    <= 1'b0;
				end
				default: begin
					out_char_q <= 8'd0;
					last_q     <= 1'b1;
					inval_q    <= 1'b1;
				end
			endcase
		end
	end

	// digit store, least significant digit at entry 0
	always_ff @(posedge clk) begin
		if (ctl.go && ctl.op == sitrd_pkg::OP_DIV && slice_end)
			digit_mem[count_q[4:0]] <= r_next;
		else if (ctl.go && ctl.op == sitrd_pkg::OP_ZERO)
			digit_mem[0] <= 4'd0;
		if (ctl.go && ctl.op == sitrd_pkg::OP_READ)
			rd_q <= digit_mem[ptr_q];
	end

	assign out_valid        = out_valid_q;
	assign out_char         = out_char_q;
	assign last             = last_q;
	assign alphabet_invalid = inval_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 6'(sitrd_pkg::MAX_DIGITS))
		else $error("digit count beyond buffer depth");

	a_inval_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && inval_q) |-> (last_q && out_char_q == 8'd0))
		else $error("invalid word must be a lone empty last word");

endmodule

[rtl/sitrd_sequencer.sv]
`timescale 1ns / 1ps

module sitrd_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sitrd_pkg::dp_stat_t  stat,
	output sitrd_pkg::seq_ctl_t  ctl,
	output logic                 idle
);

	sitrd_pkg::pc_t        pc_q;
	sitrd_pkg::ctrl_word_t word;
	logic                  taken;

	assign word = sitrd_pkg::ucode(pc_q);

	always_comb begin
		unique case (word.cond)
			sitrd_pkg::C_NEVER:    taken = 1'b0;
			sitrd_pkg::C_ALWAYS:   taken = 1'b1;
			sitrd_pkg::C_NOT_OK:   taken = !stat.ok;
			sitrd_pkg::C_MAG_ZERO: taken = stat.mag_zero;
			sitrd_pkg::C_DIV_MORE: taken = stat.div_more;
			sitrd_pkg::C_PTR_NZ:   taken = stat.ptr_nz;
			default:               taken = 1'b0;
		endcase
	end

	assign ctl.op = word.op;
	assign ctl.go = !stat.wait_step;
	assign idle   = (pc_q == sitrd_pkg::STEP_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= sitrd_pkg::STEP_IDLE;
		end else if (ctl.go) begin
			pc_q <= taken ? word.target : pc_q + 4'd1;
		end
	end

	a_ztest_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == sitrd_pkg::STEP_ZTEST && ctl.go)
		|=> (pc_q == sitrd_pkg::STEP_DIV || pc_q == sitrd_pkg::STEP_ZERO))
		else $error("zero test must lead to division or zero digit");

	a_idle_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == sitrd_pkg::STEP_IDLE && ctl.go) |=> pc_q == sitrd_pkg::STEP_CHECK)
		else $error("accepted word must go to alphabet check");

endmodule

[rtl/signed_int_to_radix_digits.sv]
// Signed integer to radix digits, one value in, a run of character words out.
// Each value gives from 1 to 32 digits, and an invalid alphabet a lone flagged word;
// each digit comes from a sliced long division (8 quotient bits a cycle), and each
// emitted character follows a registered digit-store read.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, config to defaults.
`timescale 1ns / 1ps

module signed_int_to_radix_digits (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes; the user must write only while idle, the block does not enforce it
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	// input word
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	// output words
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_char,
	output logic               last,
	output logic               alphabet_invalid
);

	logic [4:0]                    radix;
	logic [sitrd_pkg::ALPHA_W-1:0] alphabet;
	logic                          alpha_ok;
	sitrd_pkg::seq_ctl_t           ctl;
	sitrd_pkg::dp_stat_t           stat;
	logic                          idle;

	// config registers; the alphabet check is registered and tracks every write
	sitrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.radix     (radix),
		.alphabet  (alphabet),
		.alpha_ok  (alpha_ok)
	);

	// microprogram step counter; holds a step while the datapath waits on
	// the input word or on a full output register
	sitrd_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.idle   (idle)
	);

	// magnitude, divider slice, digit store and output register
	sitrd_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.in_valid         (in_valid),
		.value            (value),
		.radix            (radix),
		.alphabet         (alphabet),
		.alpha_ok         (alpha_ok),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_char         (out_char),
		.last             (last),
		.alphabet_invalid (alphabet_invalid)
	);

	// one value at a time: a word is taken only in the idle step
	assign in_stall = !idle;

endmodule

[tb/sv/signed_int_to_radix_digits_chk.sv]
`timescale 1ns / 1ps

module signed_int_to_radix_digits_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         out_char,
	input  logic               last,
	input  logic               alphabet_invalid,
	output int                 fail_count,
	output int                 words_due
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       inval;
	} char_word_t;

	// shadow of the register file
	logic [4:0]   radix_len;
	logic [127:0] alphabet;

	char_word_t due_q[$];
	char_word_t seen_w;
	char_word_t want_w;

	function automatic logic [7:0] glyph(input int idx);
		return alphabet[8*idx +: 8];
	endfunction

	function automatic bit alphabet_usable();
		int i;
		int j;
		logic [7:0] c;
		if (radix_len < 2 || radix_len > sitrd_pkg::MAX_RADIX)
			return 1'b0;
		for (i = 0; i < radix_len; i++) begin
			c = glyph(i);
			if (c == 8'd0 || c == sitrd_pkg::CH_PLUS || c == sitrd_pkg::CH_MINUS
				|| c == sitrd_pkg::CH_SPACE)
				return 1'b0;
			if (c >= sitrd_pkg::CH_TAB && c <= sitrd_pkg::CH_CR)
				return 1'b0;
			for (j = i + 1; j < radix_len; j++)
				if (glyph(j) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queues the characters one value should produce
	task automatic spell_value(input logic [31:0] raw);
		logic [3:0]  digits [sitrd_pkg::MAX_DIGITS];
		logic [31:0] mag;
		logic [31:0] base;
		int          n;
		int          i;
		if (!alphabet_usable()) begin
			due_q.push_back('{ch: 8'd0, last: 1'b1, inval: 1'b1});
			return;
		end
		base = {27'd0, radix_len};
		mag  = raw[31] ? 32'd0 - raw : raw;
		n    = 0;
		if (mag == 32'd0) begin
			digits[0] = 4'd0;
			n = 1;
		end else begin
			while (mag != 32'd0 && n < sitrd_pkg::MAX_DIGITS) begin
				digits[n] = 4'(mag % base);
				mag = mag / base;
				n++;
			end
		end
		if (raw[31])
			due_q.push_back('{ch: sitrd_pkg::CH_MINUS, last: 1'b0, inval: 1'b0});
		for (i = n - 1; i >= 0; i--)
			due_q.push_back('{ch: glyph(digits[i]), last: (i == 0), inval: 1'b0});
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t chk: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_len  = 5'd10;
			alphabet   = {64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130};
			fail_count = 0;
			due_q.delete();
			words_due <= 0;
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				seen_w = '{ch: out_char, last: last, inval: alphabet_invalid};
				if (due_q.size() == 0) begin
					report_mismatch("word with nothing due, out_char", seen_w.ch, 8'd0);
				end else begin
					want_w = due_q.pop_front();
					if (seen_w.ch !== want_w.ch)
						report_mismatch("out_char", seen_w.ch, want_w.ch);
					if (seen_w.last !== want_w.last)
						report_mismatch("last", {7'd0, seen_w.last}, {7'd0, want_w.last});
					if (seen_w.inval !== want_w.inval)
						report_mismatch("alphabet_invalid", {7'd0, seen_w.inval},
							{7'd0, want_w.inval});
				end
			end
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					sitrd_pkg::REG_RADIX:    radix_len = cfg_data[4:0];
					sitrd_pkg::REG_ALPHA_LO: alphabet[63:0] = cfg_data;
					sitrd_pkg::REG_ALPHA_HI: alphabet[127:64] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				spell_value(value);
			words_due <= due_q.size();
		end
	end

endmodule

[tb/sv/tb_signed_int_to_radix_digits.sv]
`timescale 1ns / 1ps

module tb_signed_int_to_radix_digits;

	// run limit: well above the slowest correct run
	localparam int LIMIT         = 1_000_000;
	// long receiver hold-off, enough to back the block up onto its input
	localparam int HOLD_CYCLES   = 600;
	// pause after the last word before touching config, sequencer back to idle
	localparam int SETTLE_CYCLES = 8;
	// after the last word: longer than one worst-case 32-digit value
	localparam int DRAIN_CYCLES  = 256;
	localparam int RANDOM_ITEMS  = 420;

	// ways of spoiling an otherwise good alphabet
	typedef enum {
		FLAW_NONE, FLAW_PLUS, FLAW_MINUS, FLAW_SPACE, FLAW_CTRL, FLAW_NUL, FLAW_REPEAT
	} flaw_t;

	typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         out_char;
	logic               last;
	logic               alphabet_invalid;

	int fail_count;
	int words_due;

	int       cycle_count = 0;
	int       burst_left  = 0;
	logic     hold_req;
	int       hold_cnt    = 0;
	rx_mode_t rx_mode     = RX_FLOW;
	int       rx_left     = 0;

	// values of the current directed batch
	logic [31:0] batch [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	signed_int_to_radix_digits u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.value            (value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_char         (out_char),
		.last             (last),
		.alphabet_invalid (alphabet_invalid)
	);

	signed_int_to_radix_digits_chk u_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.value            (value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_char         (out_char),
		.last             (last),
		.alphabet_invalid (alphabet_invalid),
		.fail_count       (fail_count),
		.words_due        (words_due)
	);

	// Watchdog. Also catches expectations that never get their word.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver. One long hold-off once the stimulus asks for it, otherwise it
	// drifts between free flow, light and heavy random stalls and a toggle,
	// each for a random stretch.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_cnt < HOLD_CYCLES) begin
				hold_cnt++;
				out_stall <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(16, 128);
				end
				rx_left--;
				case (rx_mode)
					RX_FLOW:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Offers one word and returns once it is taken. Words go out in bursts;
	// a new burst may open with a gap or run straight on from the last one.
	task automatic send_value(input logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic end_phase();
		in_valid   <= 1'b0;
		burst_left = 0;
	endtask

	task automatic send_batch();
		foreach (batch[i])
			send_value(batch[i]);
		end_phase();
	endtask

	// words_due is registered, hence the wait on an edge before looking at it
	task automatic wait_idle();
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	// Upper bits of the radix write are junk; only the low five count.
	task automatic apply_setting(input int radix, input logic [127:0] alpha);
		logic [63:0] d;
		d = {$urandom, $urandom};
		d[4:0] = radix[4:0];
		write_reg(sitrd_pkg::REG_RADIX, d);
		write_reg(sitrd_pkg::REG_ALPHA_LO, alpha[63:0]);
		write_reg(sitrd_pkg::REG_ALPHA_HI, alpha[127:64]);
		cfg_we <= 1'b0;
	endtask

	// Distinct allowed bytes for the characters in use, junk beyond the
	// radix (forbidden bytes there must not matter), then an optional flaw
	// dropped on one position in use.
	function automatic logic [127:0] build_alphabet(input int radix, input flaw_t flaw);
		logic [127:0] a;
		bit           taken [256];
		logic [7:0]   c;
		int           i;
		int           pos;
		int           other;
		a = {$urandom, $urandom, $urandom, $urandom};
		for (i = 0; i < 256; i++)
			taken[i] = 1'b0;
		for (i = 0; i < radix && i < sitrd_pkg::MAX_RADIX; i++) begin
			do c = 8'($urandom_range(1, 255));
			while (taken[c] || c == sitrd_pkg::CH_PLUS || c == sitrd_pkg::CH_MINUS
				|| c == sitrd_pkg::CH_SPACE
				|| (c >= sitrd_pkg::CH_TAB && c <= sitrd_pkg::CH_CR));
			taken[c] = 1'b1;
			a[8*i +: 8] = c;
		end
		if (radix >= 2 && radix <= sitrd_pkg::MAX_RADIX) begin
			pos = $urandom_range(0, radix - 1);
			case (flaw)
				FLAW_PLUS:  a[8*pos +: 8] = sitrd_pkg::CH_PLUS;
				FLAW_MINUS: a[8*pos +: 8] = sitrd_pkg::CH_MINUS;
				FLAW_SPACE: a[8*pos +: 8] = sitrd_pkg::CH_SPACE;
				FLAW_CTRL:
					a[8*pos +: 8] = 8'($urandom_range(sitrd_pkg::CH_TAB, sitrd_pkg::CH_CR));
				FLAW_NUL:   a[8*pos +: 8] = 8'd0;
				FLAW_REPEAT: begin
					other = (pos + 1 + $urandom_range(0, radix - 2)) % radix;
					a[8*pos +: 8] = a[8*other +: 8];
				end
				default: ;
			endcase
		end
		return a;
	endfunction

	// Mostly short magnitudes; full-width randoms and the two extremes for
	// the long runs.
	function automatic logic [31:0] pick_value(input int radix);
		logic [31:0] m;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3:       m = $urandom_range(0, radix * radix);
			4:       m = $urandom_range(0, 1);
			5:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: m = $urandom_range(0, 99999);
		endcase
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	initial begin
		int          sent;
		int          phase;
		int          pick;
		int          radix;
		int          n_items;
		int          f;
		logic [31:0] bad_radix [4];

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= sitrd_pkg::REG_RADIX;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		value     <= '0;
		hold_req  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// decimal out of reset: zero, sign handling, both extremes
		batch = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000};
		send_batch();

		// widest radix, plain hex alphabet
		wait_idle();
		apply_setting(sitrd_pkg::MAX_RADIX, {"fedcba98", "76543210"});
		batch = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd15};
		send_batch();

		// binary: the most negative value needs all 32 digits
		wait_idle();
		apply_setting(2, build_alphabet(2, FLAW_NONE));
		batch = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1};
		send_batch();

		// radix out of range, alphabet itself fine
		bad_radix = '{0, 1, 17, 31};
		foreach (bad_radix[i]) begin
			wait_idle();
			apply_setting(bad_radix[i], build_alphabet(sitrd_pkg::MAX_RADIX, FLAW_NONE));
			batch = '{$urandom};
			send_batch();
		end

		// each kind of bad character, and a repeat
		for (f = FLAW_PLUS; f <= FLAW_REPEAT; f++) begin
			wait_idle();
			radix = $urandom_range(2, sitrd_pkg::MAX_RADIX);
			apply_setting(radix, build_alphabet(radix, flaw_t'(f)));
			batch = '{pick_value(radix)};
			send_batch();
		end

		// Random phases. Mostly good alphabets with a long run of values,
		// now and then a spoilt one with a few. The first phase also gets the
		// long receiver hold-off while words keep being offered.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = (phase == 0) ? 9 : $urandom_range(0, 9);
			case (pick)
				0: begin
					radix = $urandom_range(0, 1) ? $urandom_range(0, 1) :
						$urandom_range(sitrd_pkg::MAX_RADIX + 1, 31);
					n_items = $urandom_range(3, 8);
					wait_idle();
					apply_setting(radix, build_alphabet(sitrd_pkg::MAX_RADIX, FLAW_NONE));
				end
				1: begin
					radix = $urandom_range(2, sitrd_pkg::MAX_RADIX);
					n_items = $urandom_range(3, 8);
					wait_idle();
					apply_setting(radix,
						build_alphabet(radix, flaw_t'($urandom_range(FLAW_PLUS, FLAW_REPEAT))));
				end
				default: begin
					if (pick == 2)
						radix = 2;
					else if (pick == 3)
						radix = sitrd_pkg::MAX_RADIX;
					else
						radix = $urandom_range(2, sitrd_pkg::MAX_RADIX);
					n_items = $urandom_range(20, 40);
					wait_idle();
					apply_setting(radix, build_alphabet(radix, FLAW_NONE));
				end
			endcase
			if (phase == 0)
				hold_req <= 1'b1;
			repeat (n_items) begin
				send_value(pick_value(radix));
				sent++;
			end
			end_phase();
			phase++;
		end

		// let every due word arrive, then watch for strays
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
